// ----- design/vpa_pkg.sv -----
// Shared types and codes for the variable partition allocator.
// No dependencies; used by the allocator top level.
`default_nettype none
package vpa_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam logic [15:0] TOTAL_SIZE_RESET = 16'd1024;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] CFG_TOTAL_SIZE = 2'd0;
    localparam logic [1:0] CFG_FIT_MODE   = 2'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] job_id;
        logic [15:0] need_size;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] base_address;
    } t_result;

    typedef struct packed {
        logic        used;
        logic [15:0] owner;
        logic [15:0] size;
        logic [15:0] base;
    } t_entry;

endpackage
`default_nettype wire

// ----- design/vpa_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/variable_partition_allocator.sv -----
// Variable partition allocator: partition table in a RAM, command sequencer.
// Depends on vpa_pkg and vpa_ram.
//
// A request is taken when start is high and busy is low; its result appears on
// o_result for exactly one cycle with o_result_valid and cannot be stalled.
// Each table entry is read through the one read port of the table RAM, in a
// read state and then an evaluate state; an entry moved on a split passes
// S_U_RD and S_U_WR, and one moved on a merge S_D_CHK, S_D_RD and S_D_WR.
// An allocate scans the entries in use and shifts entries up on a split; a
// free scans them and shifts entries down on a merge. Clear passes through
// S_CLR; an unknown command or a zero-size allocate returns its result
// straight from idle, in the cycle after it is taken. After reset the block is
// busy in S_INIT while it writes the single free entry.
`default_nettype none
module variable_partition_allocator #(
    parameter int ENTRIES = vpa_pkg::ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire vpa_pkg::t_request i_req,
    output logic                   o_result_valid,
    output vpa_pkg::t_result       o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);
    import vpa_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [17:0] {
        S_INIT   = 18'b000000000000000001,
        S_IDLE   = 18'b000000000000000010,
        S_CLR    = 18'b000000000000000100,
        S_A_RD   = 18'b000000000000001000,
        S_A_EV   = 18'b000000000000010000,
        S_A_DEC  = 18'b000000000000100000,
        S_U_RD   = 18'b000000000001000000,
        S_U_WR   = 18'b000000000010000000,
        S_U_REM  = 18'b000000000100000000,
        S_U_PICK = 18'b000000001000000000,
        S_F_RD   = 18'b000000010000000000,
        S_F_EV   = 18'b000000100000000000,
        S_F_RDN  = 18'b000001000000000000,
        S_F_EVN  = 18'b000010000000000000,
        S_F_MRG  = 18'b000100000000000000,
        S_D_CHK  = 18'b001000000000000000,
        S_D_RD   = 18'b010000000000000000,
        S_D_WR   = 18'b100000000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_pos, n_pos;
    logic            r_found, n_found;
    t_entry          r_pick, n_pick;
    t_entry          r_prev, n_prev;
    t_entry          r_next, n_next;
    logic            r_have_prev, n_have_prev;
    logic            r_front, n_front;
    logic            r_rear, n_rear;
    logic [1:0]      r_n, n_n;
    t_request        r_req, n_req;
    logic [15:0]     r_total;
    logic            r_mode;
    t_result         r_res, n_res;
    logic            r_res_valid, n_res_valid;

    logic            we;
    logic [IW-1:0]   waddr;
    t_entry          wdata;
    logic [IW-1:0]   raddr;
    logic [$bits(t_entry)-1:0] rdata_raw;
    t_entry          rd;

    logic [CW:0]     idx_inc, pos_inc, cnt_ext, rm_sum;
    logic            cand;

    vpa_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rd      = t_entry'(rdata_raw);
    assign idx_inc = {1'b0, r_idx} + (CW+1)'(1);
    assign pos_inc = {1'b0, r_pos} + (CW+1)'(1);
    assign cnt_ext = {1'b0, r_count};
    assign rm_sum  = {1'b0, r_idx} + (CW+1)'(r_n);
    assign cand    = !rd.used && (rd.size >= r_req.need_size);

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;
    assign o_cfg_ready    = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_found     = r_found;
        n_pick      = r_pick;
        n_prev      = r_prev;
        n_next      = r_next;
        n_have_prev = r_have_prev;
        n_front     = r_front;
        n_rear      = r_rear;
        n_n         = r_n;
        n_req       = r_req;
        n_res       = r_res;
        n_res_valid = 1'b0;
        we          = 1'b0;
        waddr       = r_idx[IW-1:0];
        wdata       = rd;
        raddr       = r_idx[IW-1:0];

        case (r_state)
            S_INIT, S_CLR: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = '{used: 1'b0, owner: 16'd0, size: r_total, base: 16'd0};
                n_count = CW'(1);
                n_state = S_IDLE;
                if (r_state == S_CLR) begin
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_OK, base_address: 16'd0};
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_idx = '0;
                    case (i_req.command)
                        CMD_ALLOC: begin
                            n_found = 1'b0;
                            if (i_req.need_size == 16'd0) begin
                                n_res_valid = 1'b1;
                                n_res = '{status: ST_NO_FIT, base_address: 16'd0};
                            end else begin
                                n_state = S_A_RD;
                            end
                        end
                        CMD_FREE: begin
                            n_have_prev = 1'b0;
                            n_state     = S_F_RD;
                        end
                        CMD_CLEAR: n_state = S_CLR;
                        default: begin
                            n_res_valid = 1'b1;
                            n_res = '{status: ST_OK, base_address: 16'd0};
                        end
                    endcase
                end
            end
            S_A_RD: n_state = S_A_EV;
            S_A_EV: begin
                if (cand && (!r_found || (r_mode && rd.size < r_pick.size))) begin
                    n_pick  = rd;
                    n_pos   = r_idx;
                    n_found = 1'b1;
                end
                n_idx = idx_inc[CW-1:0];
                if ((cand && !r_mode) || idx_inc == cnt_ext) begin
                    n_state = S_A_DEC;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_DEC: begin
                if (!r_found) begin
                    n_res_valid = 1'b1;
                    n_res = '{status: ST_NO_FIT, base_address: 16'd0};
                    n_state = S_IDLE;
                end else if (r_pick.size == r_req.need_size) begin
                    we    = 1'b1;
                    waddr = r_pos[IW-1:0];
                    wdata = '{used: 1'b1, owner: r_req.job_id, size: r_pick.size,
                              base: r_pick.base};
                    n_res_valid = 1'b1;
                    n_res = '{status: ST_OK, base_address: r_pick.base};
                    n_state = S_IDLE;
                end else if (cnt_ext >= (CW+1)'(ENTRIES)) begin
                    n_res_valid = 1'b1;
                    n_res = '{status: ST_FULL, base_address: 16'd0};
                    n_state = S_IDLE;
                end else if (cnt_ext > pos_inc) begin
                    n_idx   = r_count - CW'(1);
                    n_state = S_U_RD;
                end else begin
                    n_state = S_U_REM;
                end
            end
            S_U_RD: n_state = S_U_WR;
            S_U_WR: begin
                we    = 1'b1;
                waddr = idx_inc[IW-1:0];
                wdata = rd;
                if ({1'b0, r_idx} == pos_inc) begin
                    n_state = S_U_REM;
                end else begin
                    n_idx   = r_idx - CW'(1);
                    n_state = S_U_RD;
                end
            end
            S_U_REM: begin
                we    = 1'b1;
                waddr = pos_inc[IW-1:0];
                wdata = '{used: 1'b0, owner: 16'd0,
                          size: r_pick.size - r_req.need_size,
                          base: r_pick.base + r_req.need_size};
                n_state = S_U_PICK;
            end
            S_U_PICK: begin
                we    = 1'b1;
                waddr = r_pos[IW-1:0];
                wdata = '{used: 1'b1, owner: r_req.job_id, size: r_req.need_size,
                          base: r_pick.base};
                n_count     = r_count + CW'(1);
                n_res_valid = 1'b1;
                n_res       = '{status: ST_OK, base_address: r_pick.base};
                n_state     = S_IDLE;
            end
            S_F_RD: n_state = S_F_EV;
            S_F_EV: begin
                if (rd.used && rd.owner == r_req.job_id) begin
                    n_pick  = rd;
                    n_pos   = r_idx;
                    n_front = r_have_prev && !r_prev.used;
                    if (idx_inc < cnt_ext) begin
                        n_idx   = idx_inc[CW-1:0];
                        n_state = S_F_RDN;
                    end else begin
                        n_rear  = 1'b0;
                        n_state = S_F_MRG;
                    end
                end else begin
                    n_prev      = rd;
                    n_have_prev = 1'b1;
                    if (idx_inc >= cnt_ext) begin
                        n_res_valid = 1'b1;
                        n_res = '{status: ST_NOT_FOUND, base_address: 16'd0};
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_inc[CW-1:0];
                        n_state = S_F_RD;
                    end
                end
            end
            S_F_RDN: n_state = S_F_EVN;
            S_F_EVN: begin
                n_next  = rd;
                n_rear  = !rd.used;
                n_state = S_F_MRG;
            end
            S_F_MRG: begin
                we      = 1'b1;
                n_state = S_D_CHK;
                if (r_front) begin
                    waddr = IW'(r_pos - CW'(1));
                    wdata = r_prev;
                    if (r_rear) begin
                        wdata.size = r_prev.size + r_pick.size + r_next.size;
                        n_n = 2'd2;
                    end else begin
                        wdata.size = r_prev.size + r_pick.size;
                        n_n = 2'd1;
                    end
                    n_idx = r_pos;
                end else begin
                    waddr = r_pos[IW-1:0];
                    wdata = '{used: 1'b0, owner: 16'd0, size: r_pick.size,
                              base: r_pick.base};
                    if (r_rear) begin
                        wdata.size = r_pick.size + r_next.size;
                        n_n   = 2'd1;
                        n_idx = pos_inc[CW-1:0];
                    end else begin
                        n_n   = 2'd0;
                        n_idx = r_pos;
                    end
                end
            end
            S_D_CHK: begin
                if (r_n != 2'd0 && rm_sum < cnt_ext) begin
                    n_state = S_D_RD;
                end else begin
                    n_count     = r_count - CW'(r_n);
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_OK, base_address: r_pick.base};
                    n_state     = S_IDLE;
                end
            end
            S_D_RD: begin
                raddr   = rm_sum[IW-1:0];
                n_state = S_D_WR;
            end
            S_D_WR: begin
                we      = 1'b1;
                waddr   = r_idx[IW-1:0];
                wdata   = rd;
                n_idx   = idx_inc[CW-1:0];
                n_state = S_D_CHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CW'(1);
            r_res_valid <= 1'b0;
            r_total     <= TOTAL_SIZE_RESET;
            r_mode      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOTAL_SIZE: r_total <= i_cfg_data;
                    CFG_FIT_MODE:   r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_found     <= n_found;
        r_pick      <= n_pick;
        r_prev      <= n_prev;
        r_next      <= n_next;
        r_have_prev <= n_have_prev;
        r_front     <= n_front;
        r_rear      <= n_rear;
        r_n         <= n_n;
        r_req       <= n_req;
        r_res       <= n_res;
    end
endmodule
`default_nettype wire
